@@ rtl/core/cfe_pkg.sv @@
// cfe_pkg: shared types and constants of the clock offset estimator
// no dependencies
package cfe_pkg;

  localparam int MAX_SAMPLES = 32;
  localparam int SIDX_W      = $clog2(MAX_SAMPLES);
  localparam int CNT_W       = $clog2(MAX_SAMPLES + 1);
  localparam int TGT_W       = 6;
  localparam int ID_W        = 5;
  localparam int RID_W       = 16;
  localparam int TIME_W      = 64;
  localparam int QDEPTH      = 2;

  localparam logic [TGT_W-1:0] TARGET_RESET = 6'd30;
  localparam logic [TGT_W-1:0] TARGET_MIN   = 6'd2;

  typedef enum logic [1:0] {
    OP_REQ = 2'd0,
    OP_RSP = 2'd1,
    OP_RST = 2'd2,
    OP_NOP = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    KIND_REQ,
    KIND_RSP,
    KIND_RST,
    KIND_NOP
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic [RID_W-1:0]   response_id;
    logic [TIME_W-1:0]  server_time;
    logic [TIME_W-1:0]  local_time;
  } item_t;

  typedef struct packed {
    logic               accepted;
    logic               restarted;
    logic               done_res;
    logic [ID_W-1:0]    next_request_id;
    logic [CNT_W-1:0]   samples_held;
    logic               client_younger;
    logic [TIME_W-1:0]  mean_offset;
    logic [TIME_W-1:0]  time_delta;
    logic [TIME_W-1:0]  variance;
    logic [TIME_W-1:0]  mean_ping;
  } result_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_EXEC,
    ST_APPLY,
    ST_SUM_RD,
    ST_SUM_ACC,
    ST_DM_GO,
    ST_DM_WT,
    ST_V_RD,
    ST_V_DIFF,
    ST_V_M0,
    ST_V_M1,
    ST_V_ACC,
    ST_DV_GO,
    ST_DV_WT,
    ST_DP_GO,
    ST_DP_WT,
    ST_EMIT
  } state_t;

endpackage

@@ rtl/core/clock_offset_estimator.sv @@
// clock_offset_estimator: top level, input queue, sequencer and config register
// depends on cfe_pkg, cfe_front, cfe_back
// a request passes the input queue, then the sequencer states idle, exec and apply, to emit
// the request that completes a run of n samples also walks the store ram twice, for the
// sum and the variance, and runs three divides (mean, variance, ping) in the one divider
// throughput: one request at a time; a two-entry input queue and the result register
// let both sides stall on their own; synchronous reset clears all run state, target 30
module clock_offset_estimator
  import cfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input request channel
  input  logic              push,
  output logic              full,
  input  logic [1:0]        in_opcode,
  input  logic [RID_W-1:0]  in_response_id,
  input  logic [TIME_W-1:0] in_server_time,
  input  logic [TIME_W-1:0] in_local_time,
  // result channel
  output logic              empty,
  input  logic              pop,
  output logic              out_accepted,
  output logic              out_restarted,
  output logic              out_done_res,
  output logic [ID_W-1:0]   out_next_request_id,
  output logic [CNT_W-1:0]  out_samples_held,
  output logic              out_client_younger,
  output logic [TIME_W-1:0] out_mean_offset,
  output logic [TIME_W-1:0] out_time_delta,
  output logic [TIME_W-1:0] out_variance,
  output logic [TIME_W-1:0] out_mean_ping,
  // configuration: sample target
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TGT_W-1:0]  cfg_data
);

  logic [TGT_W-1:0] target_r;
  logic             q_valid, q_take, res_valid;
  item_t            q_item;
  result_t          res;

  // target register always takes writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_r <= TARGET_RESET;
    end else if (cfg_valid) begin
      target_r <= cfg_data;
    end
  end

  // front: queue and decode of the opcode
  cfe_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .opcode      (in_opcode),
    .response_id (in_response_id),
    .server_time (in_server_time),
    .local_time  (in_local_time),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_take      (q_take)
  );

  // back: state update, sample store and statistics
  cfe_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .target    (target_r),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_take    (q_take),
    .res_valid (res_valid),
    .res       (res),
    .res_pop   (pop)
  );

  // result register fields out to the ports
  assign empty               = !res_valid;
  assign out_accepted        = res.accepted;
  assign out_restarted       = res.restarted;
  assign out_done_res        = res.done_res;
  assign out_next_request_id = res.next_request_id;
  assign out_samples_held    = res.samples_held;
  assign out_client_younger  = res.client_younger;
  assign out_mean_offset     = res.mean_offset;
  assign out_time_delta      = res.time_delta;
  assign out_variance        = res.variance;
  assign out_mean_ping       = res.mean_ping;

endmodule

@@ rtl/core/cfe_ram.sv @@
// cfe_ram: generic single write, single read ram with registered read
// no dependencies
module cfe_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/cfe_div.sv @@
// cfe_div: radix-2 restoring divider, 64-bit dividend by small divisor
// depends on cfe_pkg
module cfe_div
  import cfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [TIME_W-1:0] num,
  input  logic [CNT_W-1:0]  den,
  output logic              done,
  output logic [TIME_W-1:0] quo
);

  localparam int STEP_W = $clog2(TIME_W);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [TIME_W-1:0] q_r, q_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [CNT_W-1:0]  den_r, den_nxt;
  logic [CNT_W:0]    trial;
  logic              ge;

  always_comb begin
    trial    = {rem_r, q_r[TIME_W-1]};
    ge       = trial >= {1'b0, den_r};
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    step_nxt = step_r;
    q_nxt    = q_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      q_nxt    = num;
      rem_nxt  = '0;
      den_nxt  = den;
    end else if (busy_r) begin
      rem_nxt  = ge ? CNT_W'(trial - {1'b0, den_r}) : CNT_W'(trial);
      q_nxt    = {q_r[TIME_W-2:0], ge};
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(TIME_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      step_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      step_r <= step_nxt;
    end
    q_r   <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo  = q_r;

endmodule

@@ rtl/core/cfe_front.sv @@
// cfe_front: input queue that accepts and classifies requests
// depends on cfe_pkg
module cfe_front
  import cfe_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  logic [1:0]        opcode,
  input  logic [RID_W-1:0]  response_id,
  input  logic [TIME_W-1:0] server_time,
  input  logic [TIME_W-1:0] local_time,
  output logic              q_valid,
  output item_t             q_item,
  input  logic              q_take
);

  localparam int PTR_W = $clog2(QDEPTH);

  item_t            slot_r [QDEPTH];
  logic [PTR_W-1:0] wptr_r, wptr_nxt;
  logic [PTR_W-1:0] rptr_r, rptr_nxt;
  logic [PTR_W:0]   fill_r, fill_nxt;
  logic             do_push, do_pop;
  item_t            new_item;
  kind_t            kind;

  always_comb begin
    unique case (opcode_t'(opcode))
      OP_REQ:  kind = KIND_REQ;
      OP_RSP:  kind = KIND_RSP;
      OP_RST:  kind = KIND_RST;
      default: kind = KIND_NOP;
    endcase
  end

  assign new_item = '{kind: kind, response_id: response_id,
                      server_time: server_time, local_time: local_time};

  assign full    = fill_r == (PTR_W+1)'(QDEPTH);
  assign q_valid = fill_r != '0;
  assign q_item  = slot_r[rptr_r];
  assign do_push = push && !full;
  assign do_pop  = q_take && q_valid;

  always_comb begin
    wptr_nxt = do_push ? PTR_W'(wptr_r + 1'b1) : wptr_r;
    rptr_nxt = do_pop ? PTR_W'(rptr_r + 1'b1) : rptr_r;
    fill_nxt = fill_r;
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + 1'b1;
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      fill_r <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      fill_r <= fill_nxt;
    end
    if (do_push) begin
      slot_r[wptr_r] <= new_item;
    end
  end

endmodule

@@ rtl/core/cfe_back.sv @@
// cfe_back: sequencer that applies requests, stores samples and computes results
// depends on cfe_pkg, cfe_ram, cfe_div
module cfe_back
  import cfe_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic [TGT_W-1:0] target,
  input  logic             q_valid,
  input  item_t            q_item,
  output logic             q_take,
  output logic             res_valid,
  output result_t          res,
  input  logic             res_pop
);

  state_t            state_r, state_nxt;
  item_t             it_r;
  logic [ID_W-1:0]   exp_r;
  logic [TIME_W-1:0] send_r;
  logic              yf_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [TIME_W-1:0] psum_r;
  logic              fin_r;
  logic              acc_r, rstd_r;
  logic              out_valid_r;
  result_t           out_r;
  logic [CNT_W-1:0]  i_r;
  logic [TIME_W-1:0] ping_r, absd_r;
  logic              yng_r;
  logic [TIME_W-1:0] sum_r, sq_r, d_r, p_r;
  logic [31:0]       x_r;
  logic [TIME_W-1:0] mean_r, var_r, mping_r;

  logic [TGT_W-1:0]  tgt;
  logic              rsp_ok, flip, store, finish_now, last_i, slot_free;
  logic [TIME_W-1:0] diff;
  logic [TIME_W-1:0] rdata;
  logic [63:0]       mul;
  logic [31:0]       mul_b;
  logic              ram_we;
  logic              div_start, div_done;
  logic [TIME_W-1:0] div_num, div_quo;
  logic [CNT_W-1:0]  div_den;

  // clamp of the sample target
  always_comb begin
    tgt = target;
    if (target < TARGET_MIN) begin
      tgt = TARGET_MIN;
    end else if (target > TGT_W'(MAX_SAMPLES)) begin
      tgt = TGT_W'(MAX_SAMPLES);
    end
  end

  assign rsp_ok     = it_r.kind == KIND_RSP && !fin_r &&
                      it_r.response_id == RID_W'(exp_r);
  assign flip       = rsp_ok && cnt_r != '0 && yng_r != yf_r;
  assign store      = rsp_ok && !flip;
  assign finish_now = store && (TGT_W'(cnt_r) + 1'b1) >= tgt;
  assign diff       = absd_r + (ping_r >> 1);
  assign last_i     = (i_r + 1'b1) == cnt_r;
  assign slot_free  = !out_valid_r || res_pop;

  // one 32x32 multiplier, shared by the two partial products of a square
  assign mul_b = (state_r == ST_V_M0) ? d_r[31:0] : d_r[63:32];
  assign mul   = d_r[31:0] * mul_b;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:    if (q_valid) state_nxt = ST_EXEC;
      ST_EXEC:    state_nxt = ST_APPLY;
      ST_APPLY:   state_nxt = finish_now ? ST_SUM_RD : ST_EMIT;
      ST_SUM_RD:  state_nxt = ST_SUM_ACC;
      ST_SUM_ACC: state_nxt = last_i ? ST_DM_GO : ST_SUM_RD;
      ST_DM_GO:   state_nxt = ST_DM_WT;
      ST_DM_WT:   if (div_done) state_nxt = ST_V_RD;
      ST_V_RD:    state_nxt = ST_V_DIFF;
      ST_V_DIFF:  state_nxt = ST_V_M0;
      ST_V_M0:    state_nxt = ST_V_M1;
      ST_V_M1:    state_nxt = ST_V_ACC;
      ST_V_ACC:   state_nxt = last_i ? ST_DV_GO : ST_V_RD;
      ST_DV_GO:   state_nxt = ST_DV_WT;
      ST_DV_WT:   if (div_done) state_nxt = ST_DP_GO;
      ST_DP_GO:   state_nxt = ST_DP_WT;
      ST_DP_WT:   if (div_done) state_nxt = ST_EMIT;
      ST_EMIT:    if (slot_free) state_nxt = ST_IDLE;
      default:    state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    q_take    = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    div_num   = sum_r;
    div_den   = cnt_r;
    unique case (state_r)
      ST_IDLE:  q_take = q_valid;
      ST_APPLY: ram_we = store;
      ST_DM_GO: div_start = 1'b1;
      ST_DV_GO: begin
        div_start = 1'b1;
        div_num   = sq_r;
        div_den   = cnt_r - 1'b1;
      end
      ST_DP_GO: begin
        div_start = 1'b1;
        div_num   = psum_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      exp_r       <= '0;
      send_r      <= '0;
      yf_r        <= 1'b0;
      cnt_r       <= '0;
      psum_r      <= '0;
      fin_r       <= 1'b0;
      acc_r       <= 1'b0;
      rstd_r      <= 1'b0;
      out_valid_r <= 1'b0;
      i_r         <= '0;
    end else begin
      state_r <= state_nxt;
      // result register: loaded on emit, freed when popped
      if (state_r == ST_EMIT && slot_free) begin
        out_valid_r <= 1'b1;
      end else if (res_pop && out_valid_r) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: if (q_valid) begin
          it_r <= q_item;
        end
        ST_EXEC: begin
          ping_r <= it_r.local_time - send_r;
          yng_r  <= it_r.server_time >= it_r.local_time;
          absd_r <= (it_r.server_time >= it_r.local_time) ?
                    it_r.server_time - it_r.local_time :
                    it_r.local_time - it_r.server_time;
        end
        ST_APPLY: begin
          acc_r  <= store;
          rstd_r <= flip;
          i_r    <= '0;
          sum_r  <= '0;
          if (it_r.kind == KIND_RST) begin
            exp_r  <= '0;
            send_r <= '0;
            yf_r   <= 1'b0;
            cnt_r  <= '0;
            psum_r <= '0;
            fin_r  <= 1'b0;
          end else if (it_r.kind == KIND_REQ && !fin_r) begin
            send_r <= it_r.local_time;
          end else if (flip) begin
            exp_r  <= '0;
            cnt_r  <= '0;
            psum_r <= '0;
          end else if (store) begin
            if (cnt_r == '0) begin
              yf_r <= yng_r;
            end
            psum_r <= psum_r + ping_r;
            cnt_r  <= cnt_r + 1'b1;
            if (finish_now) begin
              fin_r <= 1'b1;
            end else begin
              exp_r <= exp_r + 1'b1;
            end
          end
        end
        ST_SUM_ACC: begin
          sum_r <= sum_r + rdata;
          i_r   <= i_r + 1'b1;
        end
        ST_DM_GO: begin
          i_r  <= '0;
          sq_r <= '0;
        end
        ST_DM_WT: if (div_done) begin
          mean_r <= div_quo;
        end
        ST_V_DIFF: d_r <= rdata - mean_r;
        ST_V_M0:   p_r <= mul;
        ST_V_M1:   x_r <= mul[31:0];
        ST_V_ACC: begin
          // square mod 2^64: low product plus twice the cross product above bit 32
          sq_r <= sq_r + p_r + {x_r[30:0], 33'b0};
          i_r  <= i_r + 1'b1;
        end
        ST_DV_WT: if (div_done) begin
          var_r <= div_quo;
        end
        ST_DP_WT: if (div_done) begin
          mping_r <= div_quo;
        end
        ST_EMIT: if (slot_free) begin
          out_r.accepted        <= acc_r;
          out_r.restarted       <= rstd_r;
          out_r.done_res        <= fin_r;
          out_r.next_request_id <= exp_r;
          out_r.samples_held    <= cnt_r;
          out_r.client_younger  <= yf_r;
          out_r.mean_offset     <= fin_r ? mean_r : '0;
          out_r.time_delta      <= fin_r ? (yf_r ? mean_r : ~mean_r) : '0;
          out_r.variance        <= fin_r ? var_r : '0;
          out_r.mean_ping       <= fin_r ? mping_r : '0;
        end
        default: ;
      endcase
    end
  end

  assign res_valid = out_valid_r;
  assign res       = out_r;

  cfe_ram #(
    .WIDTH (TIME_W),
    .DEPTH (MAX_SAMPLES)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r[SIDX_W-1:0]),
    .wdata (diff),
    .raddr (i_r[SIDX_W-1:0]),
    .rdata (rdata)
  );

  cfe_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

endmodule
